[src/tac_pkg.sv]
// Shared types and constants of the tiny accumulator CPU step block.
`default_nettype none

package tac_pkg;

  // Data path width and the width of the bit-serial step counter that follows from it.
  localparam int unsigned DataW = 8;
  localparam int unsigned CntW  = $clog2(DataW);

  typedef logic [DataW-1:0] byte_t;
  typedef logic [1:0]       reg_idx_t;

  // Register D is the target of the immediate move.
  localparam reg_idx_t RegD = 2'd3;

  // Top six instruction bits that mark an IN instruction.
  localparam logic [5:0] IoInPattern = 6'b110000;

  // Arithmetic operation codes, instruction bits 5:4.
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } alu_op_e;

  // Status codes of a result transaction.
  typedef enum logic {
    STATUS_VALUE = 1'b0,
    STATUS_FAULT = 1'b1
  } status_e;

  // Start request from the sequencer to the serial arithmetic unit.
  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

endpackage

`default_nettype wire

[src/tac_if.sv]
// Valid/ready stream interfaces for instructions and results.
`default_nettype none

interface tac_in_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           instruction;
  logic [7:0]           in_value;

  modport source (output valid, output instruction, output in_value, input ready);
  modport sink   (input valid, input instruction, input in_value, output ready);
endinterface

interface tac_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_value;
  logic                 status;

  modport source (output valid, output out_value, output status, input ready);
  modport sink   (input valid, input out_value, input status, output ready);
endinterface

`default_nettype wire

[src/tiny_accumulator_cpu_step.sv]
// Top level of the tiny accumulator CPU step: decode, register file, result slot.
//
//   Channel | Dir | Payload                     | Handshake
//   in_i    | in  | instruction[8], in_value[8] | valid/ready
//   out_o   | out | out_value[8], status[1]     | valid/ready
//
// MOVI, IN, OUT and a divide by zero complete in the cycle they are accepted.
// ADD, SUB, MUL and DIV are accepted, then run 8 serial steps in the
// arithmetic unit (one bit per cycle), then write back the result.
// Reset clears all four registers and the result slot.
// A new transaction is taken only when idle and the result slot is empty
// or being drained in the same cycle.
`default_nettype none

module tiny_accumulator_cpu_step (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tac_in_if.sink     in_i,
  tac_out_if.source  out_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                state_q;
  tac_pkg::byte_t        rf_q [4];
  tac_pkg::reg_idx_t     dest_q;
  logic                  out_valid_q;
  tac_pkg::byte_t        out_value_q;
  tac_pkg::status_e      status_q;

  logic                  in_accept;
  logic                  slot_free;
  tac_pkg::reg_idx_t     rs;
  tac_pkg::reg_idx_t     rd;
  tac_pkg::alu_op_e      op;
  logic                  is_movi;
  logic                  is_io;
  logic                  is_in;
  logic                  div_zero;
  logic                  result_load;
  tac_pkg::alu_ctrl_t    alu_ctrl;
  logic                  alu_done;
  tac_pkg::byte_t        alu_result;

  // Instruction decode.
  always_comb begin
    rs       = in_i.instruction[1:0];
    rd       = in_i.instruction[3:2];
    op       = tac_pkg::alu_op_e'(in_i.instruction[5:4]);
    is_movi  = ~in_i.instruction[7];
    is_io    = in_i.instruction[7] & in_i.instruction[6];
    is_in    = (in_i.instruction[7:2] == tac_pkg::IoInPattern);
    div_zero = (op == tac_pkg::OP_DIV) && (rf_q[rs] == '0);
    // An OUT or a divide by zero fills the result slot in this cycle.
    result_load = in_accept & (is_io ? ~is_in : (~is_movi & div_zero));
  end

  // Handshake and start of the arithmetic unit.
  assign slot_free = ~out_valid_q | out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) & slot_free;
  assign in_accept  = in_i.valid & in_i.ready;

  always_comb begin
    alu_ctrl.start = in_accept & ~is_movi & ~is_io & ~div_zero;
    alu_ctrl.op    = op;
  end

  tac_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (alu_ctrl),
    .a_i      (rf_q[rd]),
    .b_i      (rf_q[rs]),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  // Sequencer, register file and result slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rf_q        <= '{default: '0};
      dest_q      <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      status_q    <= tac_pkg::STATUS_VALUE;
    end else begin
      if (out_valid_q && out_o.ready && !result_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (is_movi) begin
              rf_q[tac_pkg::RegD] <= {1'b0, in_i.instruction[6:0]};
            end else if (is_io) begin
              if (is_in) begin
                rf_q[rs] <= in_i.in_value;
              end else begin
                out_valid_q <= 1'b1;
                out_value_q <= rf_q[rs];
                status_q    <= tac_pkg::STATUS_VALUE;
              end
            end else if (div_zero) begin
              out_valid_q <= 1'b1;
              out_value_q <= '0;
              status_q    <= tac_pkg::STATUS_FAULT;
            end else begin
              dest_q  <= rd;
              state_q <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (alu_done) begin
            rf_q[dest_q] <= alu_result;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = out_value_q;
  assign out_o.status    = status_q;

endmodule

`default_nettype wire

[src/tac_alu.sv]
// Serial arithmetic unit: one bit of add/sub, multiply or divide per cycle.
`default_nettype none

module tac_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tac_pkg::alu_ctrl_t ctrl_i,
  input  wire tac_pkg::byte_t    a_i,
  input  wire tac_pkg::byte_t    b_i,
  output logic                   done_o,
  output tac_pkg::byte_t         result_o
);

  localparam logic [tac_pkg::CntW-1:0] CntLast = tac_pkg::CntW'(tac_pkg::DataW - 1);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [tac_pkg::CntW-1:0]  cnt_q, cnt_d;
  tac_pkg::alu_op_e          op_q, op_d;
  tac_pkg::byte_t            a_q, a_d;
  tac_pkg::byte_t            b_q, b_d;
  tac_pkg::byte_t            acc_q, acc_d;
  tac_pkg::byte_t            rem_q, rem_d;
  logic                      carry_q, carry_d;

  logic                      opb_bit;
  logic                      sum_bit;
  logic [tac_pkg::DataW:0]   rem_shift;
  logic [tac_pkg::DataW+1:0] rem_diff;
  logic                      q_bit;

  // One step of each operation, computed from the current shift registers.
  always_comb begin
    opb_bit   = b_q[0] ^ (op_q == tac_pkg::OP_SUB);
    sum_bit   = a_q[0] ^ opb_bit ^ carry_q;
    rem_shift = {rem_q, a_q[tac_pkg::DataW-1]};
    rem_diff  = {1'b0, rem_shift} - {2'b00, b_q};
    q_bit     = ~rem_diff[tac_pkg::DataW+1];
  end

  // Next-state logic for load and iteration.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    op_d    = op_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    carry_d = carry_q;
    if (ctrl_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      op_d    = ctrl_i.op;
      a_d     = a_i;
      b_d     = b_i;
      acc_d   = '0;
      rem_d   = '0;
      carry_d = (ctrl_i.op == tac_pkg::OP_SUB);
    end else if (busy_q) begin
      case (op_q)
        tac_pkg::OP_ADD, tac_pkg::OP_SUB: begin
          // LSB first, sum bits shift in from the top.
          acc_d   = {sum_bit, acc_q[tac_pkg::DataW-1:1]};
          carry_d = (a_q[0] & opb_bit) | (a_q[0] & carry_q) | (opb_bit & carry_q);
          a_d     = a_q >> 1;
          b_d     = b_q >> 1;
        end
        tac_pkg::OP_MUL: begin
          // Shift and add, truncated to the data width.
          if (b_q[0]) begin
            acc_d = acc_q + a_q;
          end
          a_d = a_q << 1;
          b_d = b_q >> 1;
        end
        tac_pkg::OP_DIV: begin
          // Restoring division, one quotient bit per cycle, MSB first.
          acc_d = {acc_q[tac_pkg::DataW-2:0], q_bit};
          rem_d = q_bit ? rem_diff[tac_pkg::DataW-1:0] : rem_shift[tac_pkg::DataW-1:0];
          a_d   = a_q << 1;
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and result shift registers.
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    rem_q   <= rem_d;
    carry_q <= carry_d;
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

`default_nettype wire
